// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro reports through $error only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define FTRS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// As above, with a message of the caller's choosing.
`define FTRS_ASSERT_MSG(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

`endif

// ===== rtl/ftrs_pkg.sv =====
// Types and constants for the frame time statistics block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ftrs_pkg;

  localparam int TIME_W  = 24;
  localparam int RATE_W  = 26;
  localparam int COUNT_W = 32;
  localparam int FREQ_W  = 32;
  localparam int TICKS_W = 48;

  // Serial divider: 32-bit divisor, 32 quotient bits per run
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // 256000 = 125 << 11; ticks * 125 is formed by shifts, an add and a subtract
  localparam int SCALE_SHIFT = 11;
  localparam int SCALED_W    = TICKS_W + 7;
  localparam int HI_SHIFT    = DIV_W - SCALE_SHIFT;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [TIME_W-1:0] TIME_MAX       = '1;
  localparam logic [FREQ_W-1:0] FREQ_RESET     = 32'd10000000;
  localparam logic [DIV_W-1:0]  RATE_NUMERATOR = 32'd65536000;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [TICKS_W-1:0] elapsed_ticks;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]  frame_time;
    logic [TIME_W-1:0]  average_time;
    logic [TIME_W-1:0]  min_time;
    logic [TIME_W-1:0]  max_time;
    logic [RATE_W-1:0]  frame_rate;
    logic [COUNT_W-1:0] frames_seen;
  } result_t;

  typedef struct packed {
    logic               is_clear;
    logic [TICKS_W-1:0] ticks;
  } cmd_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] rem_init;
    logic [DIV_W-1:0] low;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE_A,
    ST_SCALE_B,
    ST_CONV_START,
    ST_CONV_WAIT,
    ST_UPDATE,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_RATE_START,
    ST_RATE_WAIT,
    ST_OUT
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/ftrs_front.sv =====
// Front end: takes input words and classifies them into commands.
// Depends on ftrs_pkg; feeds ftrs_queue.
`default_nettype none

module ftrs_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_stall,
  input  wire ftrs_pkg::item_t item,
  input  wire logic          queue_full,
  output logic               push,
  output ftrs_pkg::cmd_t     cmd
);
  import ftrs_pkg::*;

  logic held;
  logic accept;

  assign push       = held && !queue_full;
  assign item_stall = held && queue_full;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.is_clear <= (item.mode == MODE_CLEAR);
      cmd.ticks    <= item.elapsed_ticks;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ftrs_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on ftrs_pkg.
`default_nettype none

module ftrs_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ftrs_pkg::cmd_t cmd_in,
  output logic                full,
  input  wire logic           pop,
  output logic                valid,
  output ftrs_pkg::cmd_t      cmd_out
);
  import ftrs_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == DEPTH_CNT);
  assign valid   = (fill != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign cmd_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ftrs_divider.sv =====
// Restoring divider, one quotient bit per cycle, DIV_W steps per run.
// Starts from a partial remainder below the divisor. Depends on ftrs_pkg.
`default_nettype none

module ftrs_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ftrs_pkg::div_req_t req,
  output ftrs_pkg::div_rsp_t      rsp
);
  import ftrs_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] steps;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     shreg;
  logic [DIV_W-1:0]     den;
  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 fits;

  always_comb begin
    trial = {rem, shreg[DIV_W-1]};
    diff  = trial - {1'b0, den};
    fits  = (trial >= {1'b0, den});
  end

  assign rsp.done = done;
  assign rsp.quo  = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        steps <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shreg shifts dividend bits out at the top and quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= req.rem_init;
      shreg <= req.low;
      den   <= req.den;
    end else if (busy) begin
      rem   <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      shreg <= {shreg[DIV_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ftrs_back.sv =====
// Back end: runs a sample through conversion, window update, average and rate; a
// clear goes straight to output. Holds the window memory and the result register.
// Depends on ftrs_pkg and drives the shared ftrs_divider.
`default_nettype none

module ftrs_back #(
  parameter int WINDOW_DEPTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [ftrs_pkg::FREQ_W-1:0] perf_frequency,
  input  wire logic                   cmd_valid,
  input  wire ftrs_pkg::cmd_t         cmd,
  output logic                        cmd_pop,
  output ftrs_pkg::div_req_t          div_req,
  input  wire ftrs_pkg::div_rsp_t     div_rsp,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output ftrs_pkg::result_t           result
);
  import ftrs_pkg::*;

  localparam int POS_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int TOTAL_W = TIME_W + $clog2(WINDOW_DEPTH);
  localparam int EXT_W   = 2 * DIV_W;
  localparam logic [POS_W-1:0]  LAST_POS   = POS_W'(WINDOW_DEPTH - 1);
  localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(WINDOW_DEPTH);

  back_state_t state;
  back_state_t state_next;

  cmd_t                cmd_q;
  logic [SCALED_W-1:0] scaled;
  logic [SCALED_W-1:0] ticks_ext;
  logic [TIME_W-1:0]   now;
  logic [TIME_W-1:0]   old_entry;
  logic [TIME_W-1:0]   window_mem [WINDOW_DEPTH];
  logic [POS_W-1:0]    write_pos;
  logic                window_full;
  logic [TOTAL_W-1:0]  running_total;
  logic [TIME_W-1:0]   least_time;
  logic                least_valid;
  logic [TIME_W-1:0]   greatest_time;
  logic [TIME_W-1:0]   mean_time;
  logic [RATE_W-1:0]   rate;
  logic [COUNT_W-1:0]  sample_count;

  logic                mem_re;
  logic                mem_we;
  logic                load_result;
  logic                overflow;
  logic [FILL_W-1:0]   filled;
  logic [EXT_W-1:0]    total_ext;
  logic [TOTAL_W-1:0]  leaving;

  assign ticks_ext = SCALED_W'(cmd_q.ticks);
  // quotient would need more than DIV_W bits (also catches a zero frequency)
  assign overflow  = (scaled >> HI_SHIFT) >= SCALED_W'(perf_frequency);
  assign total_ext = EXT_W'(running_total);
  assign leaving   = window_full ? TOTAL_W'(old_entry) : '0;

  always_comb begin
    filled = window_full ? DEPTH_FILL : FILL_W'(write_pos);
    if (filled == '0) begin
      filled = FILL_W'(1);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = cmd.is_clear ? ST_OUT : ST_SCALE_A;
        end
      end
      ST_SCALE_A:    state_next = ST_SCALE_B;
      ST_SCALE_B:    state_next = ST_CONV_START;
      ST_CONV_START: state_next = overflow ? ST_UPDATE : ST_CONV_WAIT;
      ST_CONV_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE:     state_next = ST_AVG_START;
      ST_AVG_START:  state_next = ST_AVG_WAIT;
      ST_AVG_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_RATE_START;
        end
      end
      ST_RATE_START: state_next = (mean_time == '0) ? ST_OUT : ST_RATE_WAIT;
      ST_RATE_WAIT: begin
        if (div_rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!result_valid || !result_stall) begin
          state_next = ST_IDLE;
        end
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_pop     = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    load_result = 1'b0;
    div_req     = '0;
    unique case (state)
      ST_IDLE:    cmd_pop = cmd_valid;
      ST_SCALE_A: mem_re  = 1'b1;
      ST_CONV_START: begin
        div_req.start    = !overflow;
        div_req.rem_init = DIV_W'(scaled >> HI_SHIFT);
        div_req.low      = {scaled[HI_SHIFT-1:0], {SCALE_SHIFT{1'b0}}};
        div_req.den      = perf_frequency;
      end
      ST_UPDATE:  mem_we = 1'b1;
      ST_AVG_START: begin
        div_req.start    = 1'b1;
        div_req.rem_init = total_ext[EXT_W-1:DIV_W];
        div_req.low      = total_ext[DIV_W-1:0];
        div_req.den      = DIV_W'(filled);
      end
      ST_RATE_START: begin
        div_req.start    = (mean_time != '0);
        div_req.rem_init = '0;
        div_req.low      = RATE_NUMERATOR;
        div_req.den      = DIV_W'(mean_time);
      end
      ST_OUT:     load_result = !result_valid || !result_stall;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // statistics state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos     <= '0;
      window_full   <= 1'b0;
      running_total <= '0;
      least_time    <= TIME_MAX;
      least_valid   <= 1'b0;
      greatest_time <= '0;
      mean_time     <= '0;
      rate          <= '0;
      sample_count  <= '0;
    end else begin
      if (cmd_pop && cmd.is_clear) begin
        least_time    <= TIME_MAX;
        least_valid   <= 1'b0;
        greatest_time <= '0;
      end
      if (state == ST_UPDATE) begin
        if (!least_valid || now < least_time) begin
          least_time <= now;
        end
        least_valid <= 1'b1;
        if (now > greatest_time) begin
          greatest_time <= now;
        end
        running_total <= running_total - leaving + TOTAL_W'(now);
        if (write_pos == LAST_POS) begin
          write_pos   <= '0;
          window_full <= 1'b1;
        end else begin
          write_pos <= write_pos + 1'b1;
        end
        sample_count <= sample_count + 1'b1;
      end
      if (state == ST_AVG_WAIT && div_rsp.done) begin
        mean_time <= div_rsp.quo[TIME_W-1:0];
      end
      if (state == ST_RATE_START && mean_time == '0) begin
        rate <= '0;
      end
      if (state == ST_RATE_WAIT && div_rsp.done) begin
        rate <= div_rsp.quo[RATE_W-1:0];
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_q <= cmd;
    end
    unique case (state)
      ST_SCALE_A: scaled <= (ticks_ext << 7) + ticks_ext;
      ST_SCALE_B: scaled <= scaled - (ticks_ext << 2);
      ST_CONV_START: begin
        if (overflow) begin
          now <= TIME_MAX;
        end
      end
      ST_CONV_WAIT: begin
        if (div_rsp.done) begin
          now <= (div_rsp.quo[DIV_W-1:TIME_W] != '0) ? TIME_MAX
                                                     : div_rsp.quo[TIME_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // window memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      window_mem[write_pos] <= now;
    end
    if (mem_re) begin
      old_entry <= window_mem[write_pos];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      result.frame_time   <= cmd_q.is_clear ? '0 : now;
      result.average_time <= mean_time;
      result.min_time     <= least_valid ? least_time : '0;
      result.max_time     <= greatest_time;
      result.frame_rate   <= rate;
      result.frames_seen  <= sample_count;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frame_time_rolling_stats.sv =====
// Frame time rolling statistics: min, max, windowed average and frame rate.
// A sample passes the front register and queue; the back end, one command at a time,
// scales it, converts it by serial division unless it saturates, updates the window,
// divides for the average and, unless it is 0, the rate; a clear goes to output.
// Reset (synchronous, active high) clears all control state and statistics and
// sets the frequency to 10000000; the window memory is not cleared.
`default_nettype none

module frame_time_rolling_stats #(
  parameter int WINDOW_DEPTH = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [ftrs_pkg::FREQ_W-1:0] cfg_wdata,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire ftrs_pkg::item_t             item,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output ftrs_pkg::result_t                result
);
  import ftrs_pkg::*;

  logic [FREQ_W-1:0] perf_frequency;
  logic              push;
  cmd_t              front_cmd;
  logic              queue_full;
  logic              queue_valid;
  cmd_t              queue_cmd;
  logic              pop;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      perf_frequency <= FREQ_RESET;
    end else if (cfg_we) begin
      perf_frequency <= cfg_wdata;
    end
  end

  ftrs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (front_cmd)
  );

  ftrs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (front_cmd),
    .full    (queue_full),
    .pop     (pop),
    .valid   (queue_valid),
    .cmd_out (queue_cmd)
  );

  ftrs_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  ftrs_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .perf_frequency (perf_frequency),
    .cmd_valid      (queue_valid),
    .cmd            (queue_cmd),
    .cmd_pop        (pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result)
  );

endmodule

`default_nettype wire

// ===== rtl/ftrs_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
// Depends on ftrs_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module ftrs_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire ftrs_pkg::result_t result
);
  import ftrs_pkg::*;

  `FTRS_ASSERT(a_hold_valid, clk, rst, result_valid && result_stall |=> result_valid)

  `FTRS_ASSERT(a_hold_word, clk, rst, result_valid && result_stall |=> $stable(result))

  `FTRS_ASSERT_MSG(a_min_le_max, clk, rst, result_valid |-> result.min_time <= result.max_time, "minimum above maximum")

  `FTRS_ASSERT_MSG(a_rate_zero, clk, rst, result_valid |-> ((result.average_time == '0) == (result.frame_rate == '0)), "rate and average disagree on zero")

endmodule

bind frame_time_rolling_stats ftrs_checker u_ftrs_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
